// File: hw/rtl/glos_pkg.sv
`default_nettype none

package glos_pkg;

    localparam int COORD_W = 6;
    localparam int FLOOR_W = 4;
    // line metric width, covers |a*x + b*y + c| for 6-bit coordinates
    localparam int MET_W   = 16;

    localparam logic CMD_WRITE = 1'b0;
    localparam logic CMD_QUERY = 1'b1;

    typedef struct packed {
        logic [COORD_W-1:0] fx;
        logic [COORD_W-1:0] fy;
        logic [FLOOR_W-1:0] fz;
        logic [COORD_W-1:0] tx;
        logic [COORD_W-1:0] ty;
        logic [FLOOR_W-1:0] tz;
    } t_query;

    typedef struct packed {
        logic               wr;
        logic               rd;
        logic [COORD_W-1:0] x;
        logic [COORD_W-1:0] y;
        logic [FLOOR_W-1:0] z;
        logic               mark;
    } t_map_req;

    typedef struct packed {
        logic ready;
        logic blocked;
    } t_map_rsp;

endpackage

`default_nettype wire

// File: hw/rtl/grid_line_of_sight_walk_unit.sv
`default_nettype none

// Line-of-sight walker over a bitmap of blocking cells, GRID_W x GRID_H x
// FLOORS bits in one single-port synchronous memory. A write word (command 0)
// sets or clears one cell's mark. A query word (command 1) walks
// from the cell on the lower floor toward the other cell in x and y, reading
// one bitmap bit per step on the start floor; it takes at most 2 * GRID_W
// steps, and equal cells are answered as clear without a walk. The bitmap
// read port sets the rate at one step per cycle. After reset the map is
// cleared by a pass over all GRID_W * GRID_H * FLOORS cells (65536 at
// default size) with o_ready low. A finished answer waits in an output
// register and one spare slot, so the next word may be taken while an
// answer is still unread.
module grid_line_of_sight_walk_unit import glos_pkg::*; #(
    parameter int GRID_W = 64,
    parameter int GRID_H = 64,
    parameter int FLOORS = 16
) (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_valid,
    output logic                    o_ready,
    input  wire logic               i_command,
    input  wire logic [COORD_W-1:0] i_from_x,
    input  wire logic [COORD_W-1:0] i_from_y,
    input  wire logic [FLOOR_W-1:0] i_from_z,
    input  wire logic [COORD_W-1:0] i_to_x,
    input  wire logic [COORD_W-1:0] i_to_y,
    input  wire logic [FLOOR_W-1:0] i_to_z,
    input  wire logic               i_block_mark,
    output logic                    o_valid,
    input  wire logic               i_ready,
    output logic                    o_path_clear
);

    t_query   query;
    t_map_req walk_req, map_req;
    t_map_rsp map_rsp;
    logic     walk_idle, walk_done, walk_clear;
    logic     accept, acc_write, acc_query, same_cell, walk_start;
    logic     res_valid, res_clear, out_free;

    logic     r_out_valid, r_path_clear;
    logic     r_hold_valid, r_hold_clear;

    assign query.fx = i_from_x;
    assign query.fy = i_from_y;
    assign query.fz = i_from_z;
    assign query.tx = i_to_x;
    assign query.ty = i_to_y;
    assign query.tz = i_to_z;

    assign o_ready    = map_rsp.ready && walk_idle && !r_hold_valid;
    assign accept     = i_valid && o_ready;
    assign acc_write  = accept && (i_command == CMD_WRITE);
    assign acc_query  = accept && (i_command == CMD_QUERY);
    assign same_cell  = (i_from_x == i_to_x) && (i_from_y == i_to_y)
                     && (i_from_z == i_to_z);
    assign walk_start = acc_query && !same_cell;

    always_comb begin
        map_req = walk_req;
        if (acc_write) begin
            map_req.wr   = 1'b1;
            map_req.x    = i_from_x;
            map_req.y    = i_from_y;
            map_req.z    = i_from_z;
            map_req.mark = i_block_mark;
        end
    end

    glos_map #(
        .GRID_W (GRID_W),
        .GRID_H (GRID_H),
        .FLOORS (FLOORS)
    ) u_map (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (map_req),
        .o_rsp   (map_rsp)
    );

    glos_walk #(
        .GRID_W (GRID_W)
    ) u_walk (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_start   (walk_start),
        .i_query   (query),
        .i_blocked (map_rsp.blocked),
        .o_req     (walk_req),
        .o_idle    (walk_idle),
        .o_done    (walk_done),
        .o_clear   (walk_clear)
    );

    assign res_valid = (acc_query && same_cell) || walk_done;
    assign res_clear = walk_done ? walk_clear : 1'b1;
    assign out_free  = !r_out_valid || i_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_hold_valid <= 1'b0;
        end else if (out_free) begin
            if (r_hold_valid) begin
                r_out_valid  <= 1'b1;
                r_path_clear <= r_hold_clear;
                r_hold_valid <= 1'b0;
            end else begin
                r_out_valid  <= res_valid;
                r_path_clear <= res_clear;
            end
        end else if (res_valid) begin
            // answer parks in the spare slot while the output word waits
            r_hold_valid <= 1'b1;
            r_hold_clear <= res_clear;
        end
    end

    assign o_valid      = r_out_valid;
    assign o_path_clear = r_path_clear;

    a_hold_behind_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_hold_valid |-> r_out_valid)
        else $error("spare slot full with output empty");

    a_no_result_on_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        walk_done |-> !r_hold_valid)
        else $error("walk finished while spare slot full");

    a_map_one_access: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(map_req.wr && map_req.rd))
        else $error("map read and write in the same cycle");

    a_single_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(walk_done && acc_query))
        else $error("two answers in one cycle");

endmodule

`default_nettype wire

// File: hw/rtl/glos_map.sv
`default_nettype none

module glos_map import glos_pkg::*; #(
    parameter int GRID_W = 64,
    parameter int GRID_H = 64,
    parameter int FLOORS = 16
) (
    input  wire logic     i_clk,
    input  wire logic     i_rst_n,
    input  wire t_map_req i_req,
    output t_map_rsp      o_rsp
);

    localparam int CELLS = GRID_W * GRID_H * FLOORS;
    localparam int AW    = $clog2(CELLS);

    logic          r_mem [CELLS];
    logic          r_clr_busy;
    logic [AW-1:0] r_clr_addr;
    logic          r_rd_bit;
    logic          r_rd_in_grid;

    logic          in_grid;
    logic [AW-1:0] cell_addr;
    logic [AW-1:0] mem_addr;
    logic          mem_we;
    logic          mem_wd;

    assign in_grid = (32'(i_req.x) < GRID_W) && (32'(i_req.y) < GRID_H)
                  && (32'(i_req.z) < FLOORS);
    assign cell_addr = AW'((32'(i_req.z) * GRID_H + 32'(i_req.y)) * GRID_W
                         + 32'(i_req.x));

    // the clearing sweep owns the port until the whole map is zero
    assign mem_addr = r_clr_busy ? r_clr_addr : cell_addr;
    assign mem_we   = r_clr_busy || (i_req.wr && in_grid);
    assign mem_wd   = r_clr_busy ? 1'b0 : i_req.mark;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr_busy <= 1'b1;
            r_clr_addr <= '0;
        end else if (r_clr_busy) begin
            r_clr_addr <= r_clr_addr + AW'(1);
            if (r_clr_addr == AW'(CELLS - 1)) begin
                r_clr_busy <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[mem_addr] <= mem_wd;
        end
        if (i_req.rd && !r_clr_busy) begin
            r_rd_bit <= r_mem[mem_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rd_in_grid <= 1'b0;
        end else begin
            r_rd_in_grid <= i_req.rd && in_grid;
        end
    end

    // cells off the grid never block
    assign o_rsp.ready   = !r_clr_busy;
    assign o_rsp.blocked = r_rd_in_grid && r_rd_bit;

endmodule

`default_nettype wire

// File: hw/rtl/glos_walk.sv
`default_nettype none

module glos_walk import glos_pkg::*; #(
    parameter int GRID_W = 64
) (
    input  wire logic   i_clk,
    input  wire logic   i_rst_n,
    input  wire logic   i_start,
    input  wire t_query i_query,
    input  wire logic   i_blocked,
    output t_map_req    o_req,
    output logic        o_idle,
    output logic        o_done,
    output logic        o_clear
);

    localparam int CAP  = 2 * GRID_W;
    localparam int SC_W = $clog2(CAP + 1);

    typedef enum logic [1:0] {
        S_IDLE,
        S_SETUP,
        S_WALK
    } t_state;

    t_state                    r_state;
    logic [COORD_W-1:0]        r_wx, r_wy, r_dx, r_dy;
    logic [FLOOR_W-1:0]        r_sz;
    logic [COORD_W-1:0]        r_a, r_b;
    logic                      r_xnz, r_ynz, r_xinc, r_yinc;
    logic signed [MET_W-1:0]   r_line;
    logic [SC_W-1:0]           r_steps;
    logic                      r_pend;
    logic                      r_done;
    logic                      r_clear;

    logic [COORD_W-1:0]        sx, sy, ex, ey;
    logic [FLOOR_W-1:0]        sz;
    logic [2*COORD_W-1:0]      prod;
    logic signed [MET_W-1:0]   p_s, line0;
    logic signed [MET_W-1:0]   ax, by, hor, ver, crs;
    logic [MET_W-1:0]          hor_m, ver_m, crs_m;
    logic                      arrived, step, ymove, xmove;
    logic                      walk_end;
    logic [COORD_W-1:0]        nx, ny;

    // start from the lower floor, the first cell on a tie
    always_comb begin
        if (i_query.fz > i_query.tz) begin
            sx = i_query.tx; sy = i_query.ty; sz = i_query.tz;
            ex = i_query.fx; ey = i_query.fy;
        end else begin
            sx = i_query.fx; sy = i_query.fy; sz = i_query.fz;
            ex = i_query.tx; ey = i_query.ty;
        end
    end

    // initial line value a*(x0-dx) + b*(y0-dy) = -(mx+my)*a*b
    assign prod = r_a * r_b;
    assign p_s  = $signed(MET_W'(prod));
    always_comb begin
        line0 = '0;
        if (r_xnz && r_ynz) begin
            if (r_xinc == r_yinc) begin
                line0 = r_xinc ? -(p_s <<< 1) : (p_s <<< 1);
            end
        end else if (r_xnz) begin
            line0 = r_xinc ? -p_s : p_s;
        end else if (r_ynz) begin
            line0 = r_yinc ? -p_s : p_s;
        end
    end

    assign ax = !r_xnz ? '0 : (r_xinc ?  $signed(MET_W'(r_a))
                                      : -$signed(MET_W'(r_a)));
    assign by = !r_ynz ? '0 : (r_yinc ?  $signed(MET_W'(r_b))
                                      : -$signed(MET_W'(r_b)));
    assign hor = r_line + ax;
    assign ver = r_line + by;
    assign crs = r_line + ax + by;
    assign hor_m = MET_W'(hor < 0 ? -hor : hor);
    assign ver_m = MET_W'(ver < 0 ? -ver : ver);
    assign crs_m = MET_W'(crs < 0 ? -crs : crs);

    // y decides first; x sees the updated y
    assign ymove = (r_wy != r_dy) && ((r_wx == r_dx) || hor_m > ver_m || hor_m > crs_m);
    assign ny    = ymove ? (r_yinc ? r_wy + COORD_W'(1) : r_wy - COORD_W'(1)) : r_wy;
    assign xmove = (r_wx != r_dx) && ((ny == r_dy) || ver_m > hor_m || ver_m > crs_m);
    assign nx    = xmove ? (r_xinc ? r_wx + COORD_W'(1) : r_wx - COORD_W'(1)) : r_wx;

    assign arrived = (r_wx == r_dx) && (r_wy == r_dy);
    assign step    = (r_state == S_WALK) && !(r_pend && i_blocked) && !arrived
                  && (r_steps < SC_W'(CAP));
    // blocked, arrived or out of steps
    assign walk_end = (r_state == S_WALK) && !step;

    always_comb begin
        o_req      = '0;
        o_req.rd   = step;
        o_req.x    = nx;
        o_req.y    = ny;
        o_req.z    = r_sz;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_pend  <= 1'b0;
            r_done  <= 1'b0;
            r_clear <= 1'b0;
            r_steps <= '0;
            r_wx    <= '0;
            r_wy    <= '0;
        end else begin
            r_done <= walk_end;
            case (r_state)
                S_IDLE: begin
                    if (i_start) begin
                        r_wx    <= sx;
                        r_wy    <= sy;
                        r_sz    <= sz;
                        r_dx    <= ex;
                        r_dy    <= ey;
                        r_a     <= (ey > sy) ? ey - sy : sy - ey;
                        r_b     <= (ex > sx) ? ex - sx : sx - ex;
                        r_xnz   <= (sx != ex);
                        r_ynz   <= (sy != ey);
                        r_xinc  <= (sx < ex);
                        r_yinc  <= (sy < ey);
                        r_steps <= '0;
                        r_pend  <= 1'b0;
                        r_state <= S_SETUP;
                    end
                end
                S_SETUP: begin
                    r_line  <= line0;
                    r_state <= S_WALK;
                end
                S_WALK: begin
                    if (r_pend && i_blocked) begin
                        r_clear <= 1'b0;
                        r_state <= S_IDLE;
                    end else if (arrived) begin
                        r_clear <= 1'b1;
                        r_state <= S_IDLE;
                    end else if (!step) begin
                        // step cap reached
                        r_clear <= 1'b0;
                        r_state <= S_IDLE;
                    end else begin
                        r_wx    <= nx;
                        r_wy    <= ny;
                        r_line  <= r_line + (xmove ? ax : '0) + (ymove ? by : '0);
                        r_steps <= r_steps + SC_W'(1);
                        r_pend  <= 1'b1;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_idle  = (r_state == S_IDLE) && !r_done;
    assign o_done  = r_done;
    assign o_clear = r_clear;

endmodule

`default_nettype wire
